### hw/rtl/oanav_pkg.sv
package oanav_pkg;

  typedef enum logic [2:0] {
    ModeHold     = 3'd0,
    ModeSafe     = 3'd1,
    ModeLeft     = 3'd2,
    ModeRight    = 3'd3,
    ModeOut      = 3'd4,
    ModeOutDelay = 3'd5
  } nav_mode_e;

  typedef enum logic {
    OpDetect = 1'b0,
    OpTick   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CfgBaseSpeed    = 2'd0,
    CfgTurnRateDeg  = 2'd1,
    CfgRampInterval = 2'd2,
    CfgStartDelay   = 2'd3
  } cfg_idx_e;

  // detection codes
  localparam logic [7:0] CodeSafe     = 8'd1;
  localparam logic [7:0] CodeLeft     = 8'd2;
  localparam logic [7:0] CodeRight    = 8'd3;
  localparam logic [7:0] CodeOut      = 8'd4;
  localparam logic [7:0] CodeOutDelay = 8'd5;

  localparam int unsigned RampStepCms  = 10;
  localparam logic [2:0]  RampMaxSteps = 3'd5;

  // pi/180 * 4096 * 65536, rounded
  localparam logic [22:0] DegToQ12Q16 = 23'd4685083;

  localparam logic [9:0] BaseSpeedReset    = 10'd20;
  localparam logic [8:0] TurnRateReset     = 9'd15;
  localparam logic [9:0] RampIntervalReset = 10'd50;
  localparam logic [9:0] StartDelayReset   = 10'd20;
  localparam logic [9:0] RampCountReset    = 10'd10;
  localparam logic [9:0] DelayCountReset   = 10'd20;

  localparam logic [15:0] TurnMagReset = 16'((15 * 4685083 + 32768) >> 16);

endpackage

### hw/rtl/oanav_in_if.sv
interface oanav_in_if;
  logic              valid;
  logic              ready;
  logic              operation;
  logic signed [7:0] setting;
  logic              guided;

  modport source (output valid, output operation, output setting, output guided,
                  input ready);
  modport sink   (input valid, input operation, input setting, input guided,
                  output ready);
endinterface

### hw/rtl/oanav_out_if.sv
interface oanav_out_if;
  logic               valid;
  logic               ready;
  logic               set_velocity;
  logic [10:0]        forward_speed;
  logic               set_heading;
  logic signed [15:0] heading_rate;

  modport source (output valid, output set_velocity, output forward_speed,
                  output set_heading, output heading_rate, input ready);
  modport sink   (input valid, input set_velocity, input forward_speed,
                  input set_heading, input heading_rate, output ready);
endinterface

### hw/rtl/obstacle_avoid_nav_mode_controller_top.sv
// channel   dir  handshake      payload
// req_i     in   valid/ready    operation, setting, guided
// rsp_o     out  valid/ready    set_velocity, forward_speed, set_heading, heading_rate
// apb       in   psel/penable   paddr[3:0], pwdata, prdata (pready tied high)
//
// a request is registered in the input register, then handled from there: mode, ramp and
// delay state update and a tick's command is written to the result register
// one request per cycle sustained while no tick stalls; a tick passes the input register, then the result register
// a tick stalls only when the result register is full and not being taken;
// a detection event never waits on the result side, but a request behind a stalled tick does
// async active-low reset restores default registers and the hold mode
module obstacle_avoid_nav_mode_controller_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  oanav_in_if.sink    req_i,
  oanav_out_if.source rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [9:0]  base_speed_q;
  logic [8:0]  turn_rate_q;
  logic [9:0]  ramp_interval_q;
  logic [9:0]  start_delay_q;
  logic [15:0] turn_mag_q;
  logic [31:0] turn_prod;
  logic        cfg_wr;
  oanav_pkg::cfg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = oanav_pkg::cfg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_speed_q    <= oanav_pkg::BaseSpeedReset;
      turn_rate_q     <= oanav_pkg::TurnRateReset;
      ramp_interval_q <= oanav_pkg::RampIntervalReset;
      start_delay_q   <= oanav_pkg::StartDelayReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        oanav_pkg::CfgBaseSpeed:    base_speed_q    <= pwdata[9:0];
        oanav_pkg::CfgTurnRateDeg:  turn_rate_q     <= pwdata[8:0];
        oanav_pkg::CfgRampInterval: ramp_interval_q <= pwdata[9:0];
        oanav_pkg::CfgStartDelay:   start_delay_q   <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      oanav_pkg::CfgBaseSpeed:    prdata = {22'd0, base_speed_q};
      oanav_pkg::CfgTurnRateDeg:  prdata = {23'd0, turn_rate_q};
      oanav_pkg::CfgRampInterval: prdata = {22'd0, ramp_interval_q};
      oanav_pkg::CfgStartDelay:   prdata = {22'd0, start_delay_q};
      default:                    prdata = 32'd0;
    endcase
  end

  // degrees to Q4.12 rad/s, rounded, registered from the turn-rate register
  assign turn_prod = 32'(turn_rate_q) * 32'(oanav_pkg::DegToQ12Q16) + 32'd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_mag_q <= oanav_pkg::TurnMagReset;
    end else begin
      turn_mag_q <= turn_prod[31:16];
    end
  end

  // input register
  logic              s1_valid_q;
  logic              s1_op_q;
  logic [7:0]        s1_code_q;
  logic              s1_guided_q;
  logic              s1_adv;
  logic              s1_tick;
  logic              out_valid_q;

  assign s1_tick = (s1_op_q == oanav_pkg::OpTick);
  assign s1_adv  = s1_valid_q & (!s1_tick | !out_valid_q | rsp_o.ready);
  assign req_i.ready = !s1_valid_q | s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_op_q     <= req_i.operation;
      s1_code_q   <= req_i.setting;
      s1_guided_q <= req_i.guided;
    end
  end

  // navigation state
  oanav_pkg::nav_mode_e mode_q, mode_d;
  logic [7:0]  last_code_q, last_code_d;
  logic        spin_neg_q, spin_neg_d;
  logic        extra_spin_q, extra_spin_d;
  logic [2:0]  ramp_steps_q, ramp_steps_d;
  logic [9:0]  ramp_cnt_q, ramp_cnt_d;
  logic [9:0]  delay_cnt_q, delay_cnt_d;

  logic               setv;
  logic [10:0]        speed;
  logic               seth;
  logic signed [15:0] rate;
  logic signed [15:0] rate_pos;
  logic signed [15:0] rate_neg;
  logic [11:0]        delay_x3;
  logic [9:0]         heading_thr;

  assign delay_x3    = {1'b0, start_delay_q, 1'b0} + {2'b00, start_delay_q};
  assign heading_thr = delay_x3[11:2];

  // saturate to the Q4.12 range
  assign rate_pos = (turn_mag_q > 16'd32767) ? 16'sh7fff : $signed(turn_mag_q);
  assign rate_neg = (turn_mag_q > 16'd32768) ? 16'sh8000 : $signed(~turn_mag_q + 16'd1);

  always_comb begin
    mode_d       = mode_q;
    last_code_d  = last_code_q;
    spin_neg_d   = spin_neg_q;
    extra_spin_d = extra_spin_q;
    ramp_steps_d = ramp_steps_q;
    ramp_cnt_d   = ramp_cnt_q;
    delay_cnt_d  = delay_cnt_q;
    setv  = 1'b1;
    speed = 11'd0;
    seth  = 1'b1;
    rate  = 16'sd0;

    if (!s1_tick) begin
      if (s1_code_q != last_code_q) begin
        last_code_d = s1_code_q;
        unique case (s1_code_q)
          oanav_pkg::CodeSafe:     mode_d = oanav_pkg::ModeSafe;
          oanav_pkg::CodeLeft:     mode_d = oanav_pkg::ModeLeft;
          oanav_pkg::CodeRight:    mode_d = oanav_pkg::ModeRight;
          oanav_pkg::CodeOut: begin
            mode_d = oanav_pkg::ModeOut;
            // spin flips, with one extra turn before going negative again
            if (!spin_neg_q) begin
              if (!extra_spin_q) spin_neg_d = 1'b1;
              else extra_spin_d = 1'b0;
            end else begin
              spin_neg_d   = 1'b0;
              extra_spin_d = 1'b1;
            end
          end
          oanav_pkg::CodeOutDelay: mode_d = oanav_pkg::ModeOutDelay;
          default:                 mode_d = oanav_pkg::ModeHold;
        endcase
      end
    end else if (s1_guided_q) begin
      unique case (mode_q)
        oanav_pkg::ModeSafe: begin
          setv = 1'b0;
          seth = (delay_cnt_q < heading_thr);
          if (delay_cnt_q == 10'd0) begin
            setv  = 1'b1;
            speed = {1'b0, base_speed_q}
                  + 11'(ramp_steps_q) * 11'(oanav_pkg::RampStepCms);
            if (ramp_cnt_q == 10'd0 && ramp_steps_q < oanav_pkg::RampMaxSteps) begin
              ramp_cnt_d   = ramp_interval_q;
              ramp_steps_d = ramp_steps_q + 3'd1;
            end else if (ramp_cnt_q != 10'd0) begin
              ramp_cnt_d = ramp_cnt_q - 10'd1;
            end
          end else begin
            delay_cnt_d = delay_cnt_q - 10'd1;
          end
        end
        oanav_pkg::ModeOutDelay: seth = 1'b0;
        default: begin
          if (mode_q == oanav_pkg::ModeLeft) begin
            rate = rate_neg;
          end else if (mode_q == oanav_pkg::ModeRight) begin
            rate = rate_pos;
          end else if (mode_q == oanav_pkg::ModeOut) begin
            rate = spin_neg_q ? rate_neg : rate_pos;
          end
          ramp_steps_d = 3'd0;
          ramp_cnt_d   = ramp_interval_q;
          delay_cnt_d  = start_delay_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= oanav_pkg::ModeHold;
      last_code_q  <= 8'd0;
      spin_neg_q   <= 1'b0;
      extra_spin_q <= 1'b0;
      ramp_steps_q <= 3'd0;
      ramp_cnt_q   <= oanav_pkg::RampCountReset;
      delay_cnt_q  <= oanav_pkg::DelayCountReset;
    end else if (s1_adv) begin
      mode_q       <= mode_d;
      last_code_q  <= last_code_d;
      spin_neg_q   <= spin_neg_d;
      extra_spin_q <= extra_spin_d;
      ramp_steps_q <= ramp_steps_d;
      ramp_cnt_q   <= ramp_cnt_d;
      delay_cnt_q  <= delay_cnt_d;
    end
  end

  // result register
  logic               out_setv_q;
  logic [10:0]        out_speed_q;
  logic               out_seth_q;
  logic signed [15:0] out_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_tick) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_tick) begin
      out_setv_q  <= setv;
      out_speed_q <= speed;
      out_seth_q  <= seth;
      out_rate_q  <= rate;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.set_velocity  = out_setv_q;
  assign rsp_o.forward_speed = out_speed_q;
  assign rsp_o.set_heading   = out_seth_q;
  assign rsp_o.heading_rate  = out_rate_q;

  a_ramp_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ramp_steps_q <= oanav_pkg::RampMaxSteps)
    else $error("ramp steps beyond limit");

  a_result_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_tick))
    else $error("result without a tick request");

  a_speed_needs_setv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_speed_q != 11'd0) |-> out_setv_q)
    else $error("forward speed without velocity command");

endmodule

### bench/nav_cmd_checker.sv
`timescale 1ns / 1ps

module nav_cmd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  oanav_in_if         req_i,
  oanav_out_if        rsp_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          cmds_due_o,
  output int          cmds_checked_o
);

  localparam int     SpeedStep = 10;
  localparam int     MaxSteps  = 5;
  // degrees to q4.12 rad/s, scaled by 2^16
  localparam longint DegScale  = 64'd4685083;

  typedef struct packed {
    logic        set_velocity;
    logic [10:0] forward_speed;
    logic        set_heading;
    logic [15:0] heading_rate;
  } nav_cmd_t;

  // register copies
  logic [9:0] base_speed;
  logic [8:0] turn_deg;
  logic [9:0] ramp_ivl;
  logic [9:0] start_dly;

  // controller state
  oanav_pkg::nav_mode_e mode;
  logic [7:0] last_code;
  logic       spin_neg;
  logic       extra_spin;
  logic [2:0] steps;
  logic [9:0] ramp_left;
  logic [9:0] delay_left;

  nav_cmd_t   cmd_due[$];

  function automatic logic [15:0] heading_q12(logic [8:0] deg, logic negate);
    longint mag;
    mag = (longint'(deg) * DegScale + 64'd32768) >> 16;
    if (negate) mag = -mag;
    if (mag > 32767) mag = 32767;
    else if (mag < -32768) mag = -32768;
    return 16'(mag);
  endfunction

  function automatic void restart_ramp();
    steps      = '0;
    ramp_left  = ramp_ivl;
    delay_left = start_dly;
  endfunction

  function automatic void take_code(logic [7:0] code);
    if (code == last_code) return;
    last_code = code;
    case (code)
      oanav_pkg::CodeSafe:     mode = oanav_pkg::ModeSafe;
      oanav_pkg::CodeLeft:     mode = oanav_pkg::ModeLeft;
      oanav_pkg::CodeRight:    mode = oanav_pkg::ModeRight;
      oanav_pkg::CodeOutDelay: mode = oanav_pkg::ModeOutDelay;
      oanav_pkg::CodeOut: begin
        mode = oanav_pkg::ModeOut;
        // spin flips, the extra-spin marker delays one flip back to minus
        if (!spin_neg) begin
          if (!extra_spin) spin_neg = 1'b1;
          else extra_spin = 1'b0;
        end else begin
          spin_neg   = 1'b0;
          extra_spin = 1'b1;
        end
      end
      default: mode = oanav_pkg::ModeHold;
    endcase
  endfunction

  function automatic nav_cmd_t take_tick(logic guided);
    nav_cmd_t    c;
    int unsigned three_q;
    c = '0;
    c.set_velocity = 1'b1;
    c.set_heading  = 1'b1;
    if (!guided) return c;
    case (mode)
      oanav_pkg::ModeSafe: begin
        three_q = (int'(start_dly) * 3) / 4;
        c.set_velocity = 1'b0;
        c.set_heading  = (delay_left < three_q);
        if (delay_left == 0) begin
          c.set_velocity  = 1'b1;
          c.forward_speed = 11'(int'(base_speed) + SpeedStep * int'(steps));
          // countdown sticks at zero once the ramp is complete
          if (ramp_left == 0 && steps < MaxSteps) begin
            ramp_left = ramp_ivl;
            steps     = steps + 3'd1;
          end else if (ramp_left != 0) begin
            ramp_left = ramp_left - 10'd1;
          end
        end else begin
          delay_left = delay_left - 10'd1;
        end
      end
      oanav_pkg::ModeLeft: begin
        c.heading_rate = heading_q12(turn_deg, 1'b1);
        restart_ramp();
      end
      oanav_pkg::ModeRight: begin
        c.heading_rate = heading_q12(turn_deg, 1'b0);
        restart_ramp();
      end
      oanav_pkg::ModeOut: begin
        c.heading_rate = heading_q12(turn_deg, spin_neg);
        restart_ramp();
      end
      oanav_pkg::ModeOutDelay: c.set_heading = 1'b0;
      default: restart_ramp();
    endcase
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    nav_cmd_t got;
    nav_cmd_t want;
    int       errs;
    if (!rst_ni) begin
      base_speed     = oanav_pkg::BaseSpeedReset;
      turn_deg       = oanav_pkg::TurnRateReset;
      ramp_ivl       = oanav_pkg::RampIntervalReset;
      start_dly      = oanav_pkg::StartDelayReset;
      mode           = oanav_pkg::ModeHold;
      last_code      = '0;
      spin_neg       = 1'b0;
      extra_spin     = 1'b0;
      steps          = '0;
      ramp_left      = oanav_pkg::RampCountReset;
      delay_left     = oanav_pkg::DelayCountReset;
      cmd_due.delete();
      fail_count_o   <= 0;
      cmds_due_o     <= 0;
      cmds_checked_o <= 0;
    end else begin
      errs = 0;
      // results first, so a command never meets its own request in one cycle
      if (rsp_i.valid && rsp_i.ready) begin
        got.set_velocity  = rsp_i.set_velocity;
        got.forward_speed = rsp_i.forward_speed;
        got.set_heading   = rsp_i.set_heading;
        got.heading_rate  = rsp_i.heading_rate;
        if (cmd_due.size() == 0) begin
          $error("command with no tick waiting: vel %b speed %0d hdg %b rate %0d",
                 got.set_velocity, got.forward_speed, got.set_heading,
                 $signed(got.heading_rate));
          errs++;
        end else begin
          want = cmd_due.pop_front();
          if (got.set_velocity !== want.set_velocity) begin
            $error("set_velocity: expected %b, got %b", want.set_velocity, got.set_velocity);
            errs++;
          end
          if (got.forward_speed !== want.forward_speed) begin
            $error("forward_speed: expected %0d, got %0d",
                   want.forward_speed, got.forward_speed);
            errs++;
          end
          if (got.set_heading !== want.set_heading) begin
            $error("set_heading: expected %b, got %b", want.set_heading, got.set_heading);
            errs++;
          end
          if (got.heading_rate !== want.heading_rate) begin
            $error("heading_rate: expected %0d, got %0d",
                   $signed(want.heading_rate), $signed(got.heading_rate));
            errs++;
          end
          cmds_checked_o <= cmds_checked_o + 1;
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (oanav_pkg::cfg_idx_e'(paddr[3:2]))
          oanav_pkg::CfgBaseSpeed:    base_speed = pwdata[9:0];
          oanav_pkg::CfgTurnRateDeg:  turn_deg   = pwdata[8:0];
          oanav_pkg::CfgRampInterval: ramp_ivl   = pwdata[9:0];
          oanav_pkg::CfgStartDelay:   start_dly  = pwdata[9:0];
          default: ;
        endcase
      end
      if (req_i.valid && req_i.ready) begin
        if (req_i.operation == oanav_pkg::OpDetect) take_code(req_i.setting);
        else cmd_due.push_back(take_tick(req_i.guided));
      end
      fail_count_o <= fail_count_o + errs;
      cmds_due_o   <= cmd_due.size();
    end
  end

endmodule

### bench/obstacle_avoid_nav_mode_controller_top_tb.sv
`timescale 1ns / 1ps

module obstacle_avoid_nav_mode_controller_top_tb;

  localparam int         StallLimit = 2000;
  localparam int         NumPhases  = 10;
  localparam int         PhaseItems = 95;
  localparam int         ChokeLen   = 300;
  localparam logic [7:0] CodeHold   = 8'd0;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int cmds_due;
  int cmds_checked;
  int idle_cycles = 0;
  int n_ticks     = 0;
  int n_detects   = 0;
  int n_cfg       = 0;
  int choke_asked = 0;
  int choke_done  = 0;
  bit no_idle     = 1'b0;

  oanav_in_if  req_if ();
  oanav_out_if rsp_if ();

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  obstacle_avoid_nav_mode_controller_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  nav_cmd_checker cmd_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_if),
    .rsp_i          (rsp_if),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .fail_count_o   (fail_count),
    .cmds_due_o     (cmds_due),
    .cmds_checked_o (cmds_checked)
  );

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("nothing moved for %0d cycles, giving up", StallLimit);
      $display("== FAIL ==");
      $finish;
    end
  end

  // command receiver: random stalls, plus one long hold-off on request
  initial begin
    int run;
    int stall;
    int r;
    rsp_if.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (choke_done != choke_asked) begin
        choke_done = choke_asked;
        rsp_if.ready <= 1'b0;
        repeat (ChokeLen) @(posedge clk_i);
      end else begin
        run = $urandom_range(1, 24);
        r   = $urandom_range(0, 99);
        if (no_idle || r < 50) stall = 0;
        else if (r < 88) stall = $urandom_range(1, 4);
        else stall = $urandom_range(10, 60);
        rsp_if.ready <= 1'b1;
        repeat (run) @(posedge clk_i);
        if (stall > 0) begin
          rsp_if.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 5))
      0:       return CodeHold;
      1:       return oanav_pkg::CodeLeft;
      2:       return oanav_pkg::CodeRight;
      3, 4:    return oanav_pkg::CodeOut;
      default: return oanav_pkg::CodeOutDelay;
    endcase
  endfunction

  // valid stays high into the next request when there is no gap
  task automatic push_req(oanav_pkg::op_e op, logic [7:0] code, logic guided);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.setting   <= code;
    req_if.guided    <= guided;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (op == oanav_pkg::OpTick) n_ticks++;
    else n_detects++;
  endtask

  task automatic send_detect(logic [7:0] code);
    push_req(oanav_pkg::OpDetect, code, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_tick(logic guided);
    push_req(oanav_pkg::OpTick, 8'($urandom_range(0, 255)), guided);
  endtask

  // wait for every command, then let a trailing detection event finish
  task automatic settle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (cmds_due != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(oanav_pkg::cfg_idx_e idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  task automatic configure(int phase);
    logic [9:0] base;
    logic [8:0] turn;
    logic [9:0] rint;
    logic [9:0] sdel;
    base = 10'($urandom_range(0, 1023));
    turn = 9'($urandom_range(0, 511));
    rint = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023))
                                       : 10'($urandom_range(0, 6));
    sdel = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023))
                                       : 10'($urandom_range(0, 8));
    case (phase)
      1: begin base = 10'd1023; turn = 9'd511; rint = 10'd0;    sdel = 10'd0;    end
      2: begin base = 10'd0;    turn = 9'd0;   rint = 10'd1023; sdel = 10'd1023; end
      3: begin turn = 9'd459; rint = 10'd1; sdel = 10'd2; end
      4: begin turn = 9'd458; rint = 10'd3; sdel = 10'd4; end
      default: ;
    endcase
    write_reg(oanav_pkg::CfgBaseSpeed, 32'(base));
    write_reg(oanav_pkg::CfgTurnRateDeg, 32'(turn));
    write_reg(oanav_pkg::CfgRampInterval, 32'(rint));
    write_reg(oanav_pkg::CfgStartDelay, 32'(sdel));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_cfg++;
  endtask

  task automatic run_scene();
    int kind;
    int len;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      // enter safe mode through a fresh code, then drive it through the ramp
      send_detect(pick_code());
      send_detect(oanav_pkg::CodeSafe);
      len = $urandom_range(3, 40);
      repeat (len) begin
        if ($urandom_range(0, 19) == 0) send_detect(oanav_pkg::CodeSafe);
        send_tick($urandom_range(0, 9) != 0);
      end
    end else if (kind < 80) begin
      repeat ($urandom_range(1, 6)) begin
        send_detect(pick_code());
        repeat ($urandom_range(1, 3)) send_tick($urandom_range(0, 7) != 0);
      end
    end else begin
      repeat ($urandom_range(1, 8)) begin
        push_req(oanav_pkg::op_e'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    int start;
    req_if.valid     = 1'b0;
    req_if.operation = oanav_pkg::OpDetect;
    req_if.setting   = '0;
    req_if.guided    = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hold, repeated code, turns, the three spin cases, unknown codes, safe start
    send_tick(1'b1);
    send_tick(1'b0);
    send_detect(CodeHold);
    send_detect(oanav_pkg::CodeLeft);
    send_tick(1'b1);
    send_detect(oanav_pkg::CodeRight);
    send_tick(1'b1);
    send_detect(oanav_pkg::CodeOut);
    send_tick(1'b1);
    send_detect(oanav_pkg::CodeLeft);
    send_detect(oanav_pkg::CodeOut);
    send_tick(1'b1);
    send_detect(oanav_pkg::CodeOutDelay);
    send_tick(1'b1);
    send_detect(oanav_pkg::CodeOut);
    send_tick(1'b1);
    send_detect(8'h80);
    send_tick(1'b1);
    send_detect(8'h7f);
    send_detect(8'd6);
    send_tick(1'b1);
    send_detect(oanav_pkg::CodeSafe);
    send_detect(oanav_pkg::CodeSafe);
    send_tick(1'b1);
    send_tick(1'b1);

    for (int phase = 0; phase < NumPhases; phase++) begin
      settle();
      if (phase > 0) configure(phase);
      no_idle = (phase % 4 == 2);
      if (phase == 3) begin
        // back-pressure: receiver holds off while ticks keep coming
        choke_asked++;
        wait (choke_done == choke_asked);
        no_idle = 1'b1;
        repeat (60) send_tick(1'b1);
        no_idle = 1'b0;
      end
      start = n_ticks + n_detects;
      while (n_ticks + n_detects - start < PhaseItems) run_scene();
    end
    settle();

    $display("covered %0d ticks and %0d detection events over %0d register settings",
             n_ticks, n_detects, n_cfg + 1);
    $display("%0d commands compared, %0d mismatches", cmds_checked, fail_count);
    if (fail_count == 0 && cmds_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/oanav_pkg.sv
hw/rtl/oanav_in_if.sv
hw/rtl/oanav_out_if.sv
hw/rtl/obstacle_avoid_nav_mode_controller_top.sv
bench/nav_cmd_checker.sv
bench/obstacle_avoid_nav_mode_controller_top_tb.sv
